### rtl/fat_dir_entry_scanner_top_assert.svh
// Assertion macros for the FAT directory entry scanner.
`ifndef FAT_DIR_ENTRY_SCANNER_TOP_ASSERT_SVH
`define FAT_DIR_ENTRY_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define FDES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdes assertion failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define FDES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdes assertion failed");

`endif

### rtl/fdes_pkg.sv
// Package with constants, codes and helpers for the FAT directory entry scanner.
package fdes_pkg;

  localparam int ENTRY_BYTES = 32;
  localparam int POS_W       = $clog2(ENTRY_BYTES);
  localparam int NAME_BYTES  = 11;

  localparam logic [POS_W-1:0] POS_FIRST = '0;
  localparam logic [POS_W-1:0] POS_ATTR  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_CLH0  = POS_W'(20);
  localparam logic [POS_W-1:0] POS_CLH1  = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CLL0  = POS_W'(26);
  localparam logic [POS_W-1:0] POS_CLL1  = POS_W'(27);
  localparam logic [POS_W-1:0] POS_SZ0   = POS_W'(28);
  localparam logic [POS_W-1:0] POS_SZ1   = POS_W'(29);
  localparam logic [POS_W-1:0] POS_SZ2   = POS_W'(30);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(ENTRY_BYTES - 1);

  localparam logic [7:0] LEAD_END     = 8'h00;
  localparam logic [7:0] LEAD_DELETED = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;
  localparam logic [7:0] ATTR_DIR     = 8'h10;

  localparam logic [1:0] KIND_FILE = 2'd0;
  localparam logic [1:0] KIND_DIR  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [1:0] CFG_SEARCH_MODE = 2'd0;
  localparam logic [1:0] CFG_WANTED_BASE = 2'd1;
  localparam logic [1:0] CFG_WANTED_EXT  = 2'd2;

  localparam logic [63:0] WANTED_BASE_RST = 64'h2020_2020_2020_2020;
  localparam logic [23:0] WANTED_EXT_RST  = 24'h20_2020;

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7A) begin
      return b - 8'h20;
    end
    return b;
  endfunction

endpackage

### rtl/fat_dir_entry_scanner_top.sv
// FAT32 directory entry scanner: groups directory bytes into 32-byte entries and reports them.
//
// The slave stream takes one directory byte per item in s_axis_tdata, with
// s_axis_tuser high on the byte that starts a new scan. Every 32 bytes form
// one entry. An entry whose lead byte is zero reports end of directory at
// once and stops the scan. Deleted, long-name and volume-label entries give
// no item. Other entries give one item on their last byte with the kind in
// m_axis_tuser and the first cluster, size and name match flag in tdata.
// In search mode only the first entry whose folded 8.3 name matches is
// reported, and the scan then stops until the next scan start.
// The item is registered directly from the accepted byte.
// One byte is accepted every cycle; the result register refills in the
// same cycle that its item is taken, so the input stalls only while an
// item waits and m_axis_tready is low.
// The cfg channel is always ready and writes search_mode, wanted_base and
// wanted_ext by index; other indexes are ignored.
// Reset clears the scan state, empties the result register and loads the
// registers with normal mode and an all-space name.
module fat_dir_entry_scanner_top
  import fdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // scan_start[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // first_cluster[31:0], file_size[63:32],
                                      // name_match[64], zero[71:65]
  output logic [1:0]  m_axis_tuser,   // entry_kind[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic             search_mode;
  logic [63:0]      wanted_base;
  logic [23:0]      wanted_ext;

  logic [POS_W-1:0] pos;
  logic [7:0]       lead;
  logic [7:0]       attr;
  logic             name_eq;
  logic [15:0]      clus_hi;
  logic [15:0]      clus_lo;
  logic [23:0]      size_lo;
  logic             finished;

  logic [POS_W-1:0] pos_next;
  logic [7:0]       lead_next;
  logic [7:0]       attr_next;
  logic             name_eq_next;
  logic [15:0]      clus_hi_next;
  logic [15:0]      clus_lo_next;
  logic [23:0]      size_lo_next;
  logic             finished_next;

  logic [POS_W-1:0] st_pos;
  logic [7:0]       st_lead;
  logic [7:0]       st_attr;
  logic             st_name_eq;
  logic [15:0]      st_clus_hi;
  logic [15:0]      st_clus_lo;
  logic [23:0]      st_size_lo;
  logic             st_finished;

  logic             in_accept;
  logic             emit;
  logic [1:0]       res_kind;
  logic [31:0]      res_cluster;
  logic [31:0]      res_size;
  logic             res_match;
  logic             name_cur;
  logic             skip;
  logic [127:0]     wanted_vec;
  logic [7:0]       wanted_byte;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign wanted_vec  = {40'd0, wanted_ext, wanted_base};
  assign wanted_byte = wanted_vec[{st_pos[3:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode <= 1'b0;
      wanted_base <= WANTED_BASE_RST;
      wanted_ext  <= WANTED_EXT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEARCH_MODE: search_mode <= cfg_data[0];
        CFG_WANTED_BASE: wanted_base <= cfg_data;
        CFG_WANTED_EXT:  wanted_ext  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (s_axis_tuser) begin
      st_pos      = '0;
      st_lead     = '0;
      st_attr     = '0;
      st_name_eq  = 1'b1;
      st_clus_hi  = '0;
      st_clus_lo  = '0;
      st_size_lo  = '0;
      st_finished = 1'b0;
    end else begin
      st_pos      = pos;
      st_lead     = lead;
      st_attr     = attr;
      st_name_eq  = name_eq;
      st_clus_hi  = clus_hi;
      st_clus_lo  = clus_lo;
      st_size_lo  = size_lo;
      st_finished = finished;
    end

    pos_next      = st_pos;
    lead_next     = st_lead;
    attr_next     = st_attr;
    name_eq_next  = st_name_eq;
    clus_hi_next  = st_clus_hi;
    clus_lo_next  = st_clus_lo;
    size_lo_next  = st_size_lo;
    finished_next = st_finished;

    emit        = 1'b0;
    res_kind    = KIND_FILE;
    res_cluster = '0;
    res_size    = '0;
    res_match   = 1'b0;

    name_cur = (st_pos == POS_FIRST) ? 1'b1 : st_name_eq;
    if (st_pos < POS_W'(NAME_BYTES) &&
        fold_upper(s_axis_tdata) != fold_upper(wanted_byte)) begin
      name_cur = 1'b0;
    end
    skip = st_lead == LEAD_DELETED || st_attr == ATTR_LFN ||
           (st_attr & ATTR_VOLUME) != 8'h00;

    if (!st_finished) begin
      pos_next = st_pos + POS_W'(1);
      if (st_pos == POS_FIRST) begin
        lead_next = s_axis_tdata;
      end
      if (st_pos == POS_FIRST && s_axis_tdata == LEAD_END) begin
        name_eq_next  = 1'b1;
        finished_next = 1'b1;
        emit          = 1'b1;
        res_kind      = KIND_END;
      end else begin
        name_eq_next = name_cur;
        case (st_pos)
          POS_ATTR: attr_next = s_axis_tdata;
          POS_CLH0: clus_hi_next[7:0]  = s_axis_tdata;
          POS_CLH1: clus_hi_next[15:8] = s_axis_tdata;
          POS_CLL0: clus_lo_next[7:0]  = s_axis_tdata;
          POS_CLL1: clus_lo_next[15:8] = s_axis_tdata;
          POS_SZ0:  size_lo_next = {16'd0, s_axis_tdata};
          POS_SZ1:  size_lo_next[15:8]  = s_axis_tdata;
          POS_SZ2:  size_lo_next[23:16] = s_axis_tdata;
          default: ;
        endcase
        if (st_pos == POS_LAST && !skip && !(search_mode && !name_cur)) begin
          emit        = 1'b1;
          res_kind    = ((st_attr & ATTR_DIR) != 8'h00) ? KIND_DIR : KIND_FILE;
          res_cluster = {st_clus_hi, st_clus_lo};
          res_size    = {s_axis_tdata, st_size_lo};
          res_match   = name_cur;
          if (search_mode) begin
            finished_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      lead     <= '0;
      attr     <= '0;
      name_eq  <= 1'b1;
      clus_hi  <= '0;
      clus_lo  <= '0;
      size_lo  <= '0;
      finished <= 1'b0;
    end else if (in_accept) begin
      pos      <= pos_next;
      lead     <= lead_next;
      attr     <= attr_next;
      name_eq  <= name_eq_next;
      clus_hi  <= clus_hi_next;
      clus_lo  <= clus_lo_next;
      size_lo  <= size_lo_next;
      finished <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      m_axis_tuser <= res_kind;
      m_axis_tdata <= {7'd0, res_match, res_size, res_cluster};
    end
  end

`include "fat_dir_entry_scanner_top_assert.svh"

  `FDES_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
  `FDES_ASSERT_NOW(a_end_has_no_payload, m_axis_tvalid && m_axis_tuser == KIND_END,
                   m_axis_tdata == 72'd0)
  `FDES_ASSERT_NEXT(a_end_stops_scan, in_accept && emit && res_kind == KIND_END,
                    finished && m_axis_tvalid)
  `FDES_ASSERT_NEXT(a_pos_advances, in_accept && !st_finished,
                    pos == $past(st_pos) + POS_W'(1))

endmodule
